// ===== sv/hmt_pkg.sv =====
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared types and constants of the heartbeat membership table.
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam int unsigned ENTRIES_DEF = 64;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned HB_W    = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned OCNT_W  = 7;
  localparam int unsigned CIDX_W  = 4;
  localparam int unsigned CDATA_W = 16;

  localparam logic [ID_W-1:0]  SELF_ID_RST        = 8'd1;
  localparam logic [ID_W-1:0]  MAX_ID_RST         = 8'd63;
  localparam logic [PER_W-1:0] GOSSIP_PERIOD_RST  = 16'd2;
  localparam logic [PER_W-1:0] REMOVE_TIMEOUT_RST = 16'd20;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_MERGE = 2'd1,
    CMD_JOIN  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_TICK      = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_ADDED     = 3'd3,
    ST_REJECTED  = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_SELF_ID        = 4'd0,
    REG_MAX_ID         = 4'd1,
    REG_GOSSIP_PERIOD  = 4'd2,
    REG_REMOVE_TIMEOUT = 4'd3
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [ID_W-1:0]   member_id;
    logic [PORT_W-1:0] member_port;
    logic [HB_W-1:0]   member_heartbeat;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              gossip_due;
    logic [OCNT_W-1:0] removed_count;
    logic [OCNT_W-1:0] member_count;
    logic [HB_W-1:0]   own_heartbeat;
  } result_t;

  typedef struct packed {
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    logic [HB_W-1:0]   heartbeat;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic self_match;
    logic member_match;
    logic aged;
    logic hb_less;
  } cmp_flags_t;

endpackage

// ===== sv/hmt_stream_if.sv =====
// ----------------------------------------------------------------------------
// hmt_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface hmt_stream_if #(
  parameter type data_t = logic
);

  logic  valid;
  logic  ready;
  data_t data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

// ===== sv/heartbeat_membership_table.sv =====
// ----------------------------------------------------------------------------
// heartbeat_membership_table
// Gossip heartbeat member table with aging, self heartbeat and gossip timer.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one command per transaction (tick, merge, join);
// out_ch returns exactly one result per command; cfg_ch writes the
// self_id, max_id, gossip_period and remove_timeout registers and is always
// ready. Write configuration only while no command is in flight.
// Each command reads every table slot once through the single read port of
// the entry memory, one slot per cycle, and the shared compare unit checks
// the slot in the following cycle, from the registered read data.
// in_ch is ready again as soon as the result is loaded into the output
// register, so no new command is taken while one is in flight.
// The result sits in an output register: a new command is taken while it
// waits, and only the final commit step waits for the receiver.
// Reset clears all valid bits, the member count, own heartbeat and time,
// loads register defaults and the gossip countdown; the entry memory itself
// is not cleared. Enter the self entry with a join command after reset.
// ----------------------------------------------------------------------------
module heartbeat_membership_table #(
  parameter int unsigned Entries = hmt_pkg::ENTRIES_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  hmt_stream_if.sink   cfg_ch,
  hmt_stream_if.sink   in_ch,
  hmt_stream_if.source out_ch
);

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_FINISH
  } state_e;

  state_e                          state_q;
  logic [IdxW-1:0]                 scan_q;
  logic                            ev_q;
  logic [IdxW-1:0]                 ev_idx_q;
  hmt_pkg::item_t                  item_q;
  logic [Entries-1:0]              valid_q;
  logic [CntW-1:0]                 count_q;
  logic [CntW-1:0]                 removed_q;
  logic                            found_q;
  logic [IdxW-1:0]                 match_idx_q;
  logic [hmt_pkg::PORT_W-1:0]      match_port_q;
  logic                            hb_less_q;
  logic                            free_found_q;
  logic [IdxW-1:0]                 free_idx_q;
  logic [hmt_pkg::HB_W-1:0]        self_hb_q;
  logic [hmt_pkg::PER_W-1:0]       cd_q;
  logic [hmt_pkg::TIME_W-1:0]      now_q;
  logic [hmt_pkg::ID_W-1:0]        self_id_q;
  logic [hmt_pkg::ID_W-1:0]        max_id_q;
  logic [hmt_pkg::PER_W-1:0]       period_q;
  logic [hmt_pkg::PER_W-1:0]       timeout_q;
  logic                            out_valid_q;
  hmt_pkg::result_t                out_q;

  hmt_pkg::entry_t     rdata;
  hmt_pkg::cmp_flags_t flags;
  hmt_pkg::entry_t     wdata;
  hmt_pkg::result_t    result;
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;

  logic                      is_tick;
  logic                      is_member_cmd;
  logic                      ev_valid;
  logic                      drop;
  logic                      self_wr;
  logic                      hit;
  logic                      free_hit;
  logic                      fin_go;
  logic                      fin_upd;
  logic                      fin_add;
  logic [hmt_pkg::HB_W-1:0]  self_hb_inc;
  logic [hmt_pkg::PER_W-1:0] cd_dec;
  logic                      due;
  logic [2:0]                status;

  hmt_entry_ram #(
    .Depth (Entries),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wdata),
    .raddr_i (scan_q),
    .rdata_o (rdata)
  );

  hmt_cmp_unit u_cmp (
    .entry_i     (rdata),
    .self_id_i   (self_id_q),
    .member_id_i (item_q.member_id),
    .heartbeat_i (item_q.member_heartbeat),
    .now_i       (now_q),
    .timeout_i   (timeout_q),
    .flags_o     (flags)
  );

  assign is_tick       = (item_q.command == hmt_pkg::CMD_TICK);
  assign is_member_cmd = (item_q.command == hmt_pkg::CMD_MERGE) ||
                         (item_q.command == hmt_pkg::CMD_JOIN);
  assign ev_valid      = valid_q[ev_idx_q];
  assign drop     = ev_q && is_tick && ev_valid && !flags.self_match && flags.aged;
  assign self_wr  = ev_q && is_tick && ev_valid && flags.self_match;
  assign hit      = ev_q && is_member_cmd && ev_valid && flags.member_match && !found_q;
  assign free_hit = ev_q && is_member_cmd && !ev_valid && !free_found_q;

  assign self_hb_inc = self_hb_q + 32'd1;
  assign cd_dec      = cd_q - 16'd1;
  assign due         = is_tick && (cd_dec == '0);
  assign fin_go      = (state_q == S_FINISH) && (!out_valid_q || out_ch.ready);

  always_comb begin
    fin_upd = 1'b0;
    fin_add = 1'b0;
    priority if (is_tick) begin
      status = hmt_pkg::ST_TICK;
    end else if (is_member_cmd && found_q) begin
      if ((item_q.command == hmt_pkg::CMD_MERGE) && hb_less_q) begin
        status  = hmt_pkg::ST_UPDATED;
        fin_upd = 1'b1;
      end else begin
        status = hmt_pkg::ST_UNCHANGED;
      end
    end else if (is_member_cmd && (item_q.member_id > max_id_q)) begin
      status = hmt_pkg::ST_REJECTED;
    end else if (is_member_cmd && free_found_q) begin
      status  = hmt_pkg::ST_ADDED;
      fin_add = 1'b1;
    end else if (is_member_cmd) begin
      status = hmt_pkg::ST_FULL;
    end else begin
      status = hmt_pkg::ST_UNCHANGED;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx_q;
    wdata     = rdata;
    if (self_wr) begin
      ram_we          = 1'b1;
      wdata.heartbeat = self_hb_inc;
    end else if (fin_go && (fin_upd || fin_add)) begin
      ram_we          = 1'b1;
      ram_waddr       = fin_upd ? match_idx_q : free_idx_q;
      wdata.id        = item_q.member_id;
      wdata.port      = fin_upd ? match_port_q : item_q.member_port;
      wdata.heartbeat = item_q.member_heartbeat;
      wdata.stamp     = now_q;
    end
  end

  always_comb begin
    result.status        = status;
    result.gossip_due    = due;
    result.removed_count = hmt_pkg::OCNT_W'(removed_q);
    result.member_count  = fin_add ? hmt_pkg::OCNT_W'(count_q + CntW'(1))
                                   : hmt_pkg::OCNT_W'(count_q);
    result.own_heartbeat = is_tick ? self_hb_inc : self_hb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_q       <= '0;
      ev_q         <= 1'b0;
      ev_idx_q     <= '0;
      item_q       <= '0;
      valid_q      <= '0;
      count_q      <= '0;
      removed_q    <= '0;
      found_q      <= 1'b0;
      match_idx_q  <= '0;
      match_port_q <= '0;
      hb_less_q    <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      self_hb_q    <= '0;
      cd_q         <= hmt_pkg::GOSSIP_PERIOD_RST;
      now_q        <= '0;
      self_id_q    <= hmt_pkg::SELF_ID_RST;
      max_id_q     <= hmt_pkg::MAX_ID_RST;
      period_q     <= hmt_pkg::GOSSIP_PERIOD_RST;
      timeout_q    <= hmt_pkg::REMOVE_TIMEOUT_RST;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      ev_q <= (state_q == S_SCAN);

      if (cfg_ch.valid) begin
        unique case (cfg_ch.data.index)
          hmt_pkg::REG_SELF_ID:        self_id_q <= cfg_ch.data.value[hmt_pkg::ID_W-1:0];
          hmt_pkg::REG_MAX_ID:         max_id_q  <= cfg_ch.data.value[hmt_pkg::ID_W-1:0];
          hmt_pkg::REG_GOSSIP_PERIOD:  period_q  <= cfg_ch.data.value;
          hmt_pkg::REG_REMOVE_TIMEOUT: timeout_q <= cfg_ch.data.value;
          default: ;
        endcase
      end

      if (out_ch.ready && !fin_go) begin
        out_valid_q <= 1'b0;
      end

      if (drop) begin
        valid_q[ev_idx_q] <= 1'b0;
        count_q           <= count_q - CntW'(1);
        removed_q         <= removed_q + CntW'(1);
      end
      if (hit) begin
        found_q      <= 1'b1;
        match_idx_q  <= ev_idx_q;
        match_port_q <= rdata.port;
        hb_less_q    <= flags.hb_less;
      end
      if (free_hit) begin
        free_found_q <= 1'b1;
        free_idx_q   <= ev_idx_q;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_q       <= in_ch.data;
            scan_q       <= '0;
            removed_q    <= '0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          ev_idx_q <= scan_q;
          if (scan_q == LastIdx) begin
            state_q <= S_WAIT;
          end else begin
            scan_q <= scan_q + IdxW'(1);
          end
        end
        S_WAIT: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (fin_go) begin
            out_valid_q <= 1'b1;
            out_q       <= result;
            state_q     <= S_IDLE;
            if (fin_add) begin
              valid_q[free_idx_q] <= 1'b1;
              count_q             <= count_q + CntW'(1);
            end
            if (is_tick) begin
              self_hb_q <= self_hb_inc;
              now_q     <= now_q + 32'd1;
              cd_q      <= due ? period_q : cd_dec;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_q == S_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

endmodule

// ===== sv/hmt_entry_ram.sv =====
// ----------------------------------------------------------------------------
// hmt_entry_ram
// Member entry storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hmt_entry_ram #(
  parameter int unsigned Depth = hmt_pkg::ENTRIES_DEF,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  hmt_pkg::entry_t      wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output hmt_pkg::entry_t      rdata_o
);

  hmt_pkg::entry_t mem_q [Depth];
  hmt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/hmt_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// hmt_cmp_unit
// Compare unit shared by every scan step: id matches, age check, heartbeat.
// ----------------------------------------------------------------------------
module hmt_cmp_unit (
  input  hmt_pkg::entry_t                 entry_i,
  input  logic [hmt_pkg::ID_W-1:0]        self_id_i,
  input  logic [hmt_pkg::ID_W-1:0]        member_id_i,
  input  logic [hmt_pkg::HB_W-1:0]        heartbeat_i,
  input  logic [hmt_pkg::TIME_W-1:0]      now_i,
  input  logic [hmt_pkg::PER_W-1:0]       timeout_i,
  output hmt_pkg::cmp_flags_t             flags_o
);

  logic [hmt_pkg::TIME_W-1:0] age;

  assign age = now_i - entry_i.stamp;

  always_comb begin
    flags_o.self_match   = (entry_i.id == self_id_i);
    flags_o.member_match = (entry_i.id == member_id_i);
    flags_o.aged         = (age > hmt_pkg::TIME_W'(timeout_i));
    flags_o.hb_less      = (entry_i.heartbeat < heartbeat_i);
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick, merge, join and unused command codes into the membership table under
// several register settings, with random source and sink stalls. A
// scoreboard class keeps its own copy of the table, the timers and the self
// heartbeat, predicts one report per accepted command and compares every
// report field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import hmt_pkg::*;

  localparam int unsigned SLOTS = ENTRIES_DEF;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int unsigned LAST_CIDX = (1 << CIDX_W) - 1;

  class membership_scoreboard;
    logic [ID_W-1:0]   self_id;
    logic [ID_W-1:0]   max_id;
    logic [PER_W-1:0]  gossip_period;
    logic [PER_W-1:0]  remove_timeout;
    bit                slot_live [SLOTS];
    entry_t            slot [SLOTS];
    logic [HB_W-1:0]   self_hb;
    logic [PER_W-1:0]  countdown;
    logic [TIME_W-1:0] now_time;
    int unsigned       live;
    result_t           expected_reports [$];
    int unsigned       failures;

    function new();
      self_id        = SELF_ID_RST;
      max_id         = MAX_ID_RST;
      gossip_period  = GOSSIP_PERIOD_RST;
      remove_timeout = REMOVE_TIMEOUT_RST;
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot[i]      = '0;
      end
      self_hb   = '0;
      countdown = GOSSIP_PERIOD_RST;
      now_time  = '0;
      live      = 0;
      failures  = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void apply_register(cfg_t c);
      case (c.index)
        REG_SELF_ID:        self_id = c.value[ID_W-1:0];
        REG_MAX_ID:         max_id = c.value[ID_W-1:0];
        REG_GOSSIP_PERIOD:  gossip_period = c.value[PER_W-1:0];
        REG_REMOVE_TIMEOUT: remove_timeout = c.value[PER_W-1:0];
        default: ;
      endcase
    endfunction

    function int find_slot(logic [ID_W-1:0] id);
      foreach (slot_live[i]) begin
        if (slot_live[i] && slot[i].id == id) return i;
      end
      return -1;
    endfunction

    function status_e insert_member(item_t it);
      if (it.member_id > max_id) return ST_REJECTED;
      foreach (slot_live[i]) begin
        if (!slot_live[i]) begin
          slot_live[i]      = 1'b1;
          slot[i].id        = it.member_id;
          slot[i].port      = it.member_port;
          slot[i].heartbeat = it.member_heartbeat;
          slot[i].stamp     = now_time;
          live++;
          return ST_ADDED;
        end
      end
      return ST_FULL;
    endfunction

    function void predict_command(item_t it);
      result_t           r;
      int                k;
      int unsigned       removed;
      logic [TIME_W-1:0] age;
      r = '0;
      removed = 0;
      r.status = ST_UNCHANGED;
      case (it.command)
        CMD_TICK: begin
          r.status = ST_TICK;
          foreach (slot_live[i]) begin
            age = now_time - slot[i].stamp;
            if (slot_live[i] && slot[i].id != self_id && age > TIME_W'(remove_timeout)) begin
              slot_live[i] = 1'b0;
              live--;
              removed++;
            end
          end
          self_hb = self_hb + 1'b1;
          foreach (slot_live[i]) begin
            if (slot_live[i] && slot[i].id == self_id) slot[i].heartbeat = self_hb;
          end
          countdown = countdown - 1'b1;
          if (countdown == '0) begin
            r.gossip_due = 1'b1;
            countdown = gossip_period;
          end
          now_time = now_time + 1'b1;
        end
        CMD_MERGE: begin
          k = find_slot(it.member_id);
          if (k < 0) begin
            r.status = insert_member(it);
          end else if (slot[k].heartbeat < it.member_heartbeat) begin
            slot[k].heartbeat = it.member_heartbeat;
            slot[k].stamp     = now_time;
            r.status = ST_UPDATED;
          end
        end
        CMD_JOIN: begin
          if (find_slot(it.member_id) < 0) r.status = insert_member(it);
        end
        default: ;
      endcase
      r.removed_count = removed[OCNT_W-1:0];
      r.member_count  = live[OCNT_W-1:0];
      r.own_heartbeat = self_hb;
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [HB_W-1:0] want, logic [HB_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void compare_report(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        $error("report with no command pending: status %0d", got.status);
        failures++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("status", HB_W'(want.status), HB_W'(got.status));
      compare_field("gossip_due", HB_W'(want.gossip_due), HB_W'(got.gossip_due));
      compare_field("removed_count", HB_W'(want.removed_count), HB_W'(got.removed_count));
      compare_field("member_count", HB_W'(want.member_count), HB_W'(got.member_count));
      compare_field("own_heartbeat", want.own_heartbeat, got.own_heartbeat);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_en;
  membership_scoreboard sb;

  hmt_stream_if #(.data_t(cfg_t))    cfg_ch ();
  hmt_stream_if #(.data_t(item_t))   in_ch ();
  hmt_stream_if #(.data_t(result_t)) out_ch ();

  heartbeat_membership_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2500000;
    $display("heartbeat_membership_table test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.compare_report(out_ch.data);
  end

  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall == 0 && idle_en && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic item_t make_item(logic [1:0] cmd, logic [ID_W-1:0] id,
                                      logic [PORT_W-1:0] port, logic [HB_W-1:0] hb);
    item_t it;
    it.command          = cmd;
    it.member_id        = id;
    it.member_port      = port;
    it.member_heartbeat = hb;
    return it;
  endfunction

  function automatic item_t random_item(int id_hi, int tick_pct);
    item_t it;
    int    pick;
    it.member_id   = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, id_hi));
    it.member_port = PORT_W'($urandom);
    case ($urandom_range(0, 3))
      0: it.member_heartbeat = $urandom_range(0, 63);
      1: it.member_heartbeat = $urandom;
      2: it.member_heartbeat = $urandom_range(0, 1) ? '1 : '0;
      default: it.member_heartbeat = $urandom_range(0, 1000);
    endcase
    pick = $urandom_range(0, 19);
    if ($urandom_range(0, 99) < tick_pct) it.command = CMD_TICK;
    else if (pick == 0) it.command = CMD_IGNORED;
    else if (pick <= 10) it.command = CMD_MERGE;
    else it.command = CMD_JOIN;
    return it;
  endfunction

  task automatic send_command(input item_t it);
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.predict_command(it);
  endtask

  task automatic pause_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
  endtask

  // drop valid, then hold until every report is back
  task automatic settle();
    pause_input(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] value);
    cfg_t c;
    c.index = idx;
    c.value = value;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.apply_register(c);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [ID_W-1:0] self_v, input logic [ID_W-1:0] max_v,
                           input logic [PER_W-1:0] period_v, input logic [PER_W-1:0] timeout_v,
                           input int n_items, input int id_hi, input int tick_pct);
    settle();
    write_register(REG_SELF_ID, {ID_W'($urandom), self_v});
    write_register(REG_MAX_ID, {ID_W'($urandom), max_v});
    write_register(REG_GOSSIP_PERIOD, period_v);
    write_register(REG_REMOVE_TIMEOUT, timeout_v);
    write_register(CIDX_W'($urandom_range(REG_REMOVE_TIMEOUT + 1, LAST_CIDX)), CDATA_W'($urandom));
    send_command(make_item(CMD_JOIN, self_v, PORT_W'($urandom), $urandom_range(0, 15)));
    for (int n = 0; n < n_items; n++) begin
      if (idle_en && $urandom_range(0, 4) == 0) pause_input($urandom_range(1, 19));
      if ($urandom_range(0, 59) == 0) settle();
      send_command(random_item(id_hi, tick_pct));
    end
  endtask

  initial begin
    sb = new();
    idle_en = 1'b1;
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_command(make_item(CMD_TICK, '0, '0, '0));
    send_command(make_item(CMD_JOIN, 8'd1, '1, '0));
    send_command(make_item(CMD_JOIN, 8'd0, '0, '1));
    send_command(make_item(CMD_JOIN, 8'd63, 16'h1234, '0));
    send_command(make_item(CMD_JOIN, 8'd64, 16'h00ff, 32'd5));
    send_command(make_item(CMD_MERGE, '1, '1, '1));
    send_command(make_item(CMD_MERGE, 8'd0, 16'h5555, '1));
    send_command(make_item(CMD_MERGE, 8'd63, 16'haaaa, 32'd1));
    send_command(make_item(CMD_MERGE, 8'd63, 16'haaaa, 32'd1));
    pause_input($urandom_range(1, 19));
    send_command(make_item(CMD_MERGE, 8'd5, 16'h0f0f, 32'd7));
    send_command(make_item(CMD_JOIN, 8'd5, 16'hf0f0, 32'hffff_0000));
    send_command(make_item(CMD_IGNORED, '1, '1, '1));
    send_command(make_item(CMD_MERGE, 8'd1, 16'h0001, 32'd100));
    send_command(make_item(CMD_TICK, '1, '1, '1));
    send_command(make_item(CMD_TICK, '0, '0, '0));
    send_command(make_item(CMD_TICK, 8'h5a, 16'ha5a5, 32'h8000_0001));
    send_command(make_item(CMD_JOIN, 8'd0, '0, '0));

    run_phase(8'd1, 8'd63, 16'd2, 16'd20, 150, 70, 30);
    run_phase(8'd0, 8'd255, 16'd1, 16'd65535, 200, 255, 10);
    run_phase(8'd255, 8'd255, 16'd65535, 16'd0, 150, 255, 30);
    idle_en = 1'b0;
    run_phase(8'd7, 8'd0, 16'd0, 16'd3, 100, 8, 30);
    idle_en = 1'b1;
    run_phase(8'd40, 8'd100, 16'd3, 16'd10, 200, 110, 35);
    run_phase(8'd1, 8'd63, 16'd2, 16'd20, 200, 70, 30);
    settle();
    idle_en = 1'b0;
    run_phase(8'd12, 8'd200, 16'd5, 16'd40, 250, 90, 25);

    settle();
    repeat (80) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("heartbeat_membership_table test passed");
    end else begin
      $display("heartbeat_membership_table test failed");
    end
    $finish;
  end

endmodule
